// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk; ASSERT_CLKD is disabled in reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define ASSERT_CLKD(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

// ===== rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// request codes, result codes and shared types of the semaphore engine
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int SEM_ID_W   = 4;
	localparam int PID_W      = 5;
	localparam int PASS_IN_W  = 8;
	localparam int STATUS_W   = 3;
	localparam int PASS_OUT_W = 8;
	localparam int SID_VALS   = 2 ** SEM_ID_W;

	typedef enum logic [1:0] {
		FN_INIT = 2'd0,
		FN_WAIT = 2'd1,
		FN_POST = 2'd2,
		FN_NOP  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED   = 3'd0,
		ST_BLOCKED   = 3'd1,
		ST_WOKEN     = 3'd2,
		ST_NO_ID     = 3'd3,
		ST_SATURATED = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [SEM_ID_W-1:0]   sem_id_out;
		logic [PID_W-1:0]      woken_pid;
		logic                  woken_valid;
		logic [PASS_OUT_W-1:0] passes_now;
	} result_t;

	// strobes from the sequencer to the storage
	typedef struct packed {
		logic ent_rd;
		logic ent_wr;
		logic wt_rd;
		logic wt_wr;
	} mem_ctrl_t;

endpackage

// ===== rtl/cse_store.sv =====
// ----------------------------------------------------------------------------
// cse_store
// semaphore table (count, queue head, queue length) and waiter memory
// ----------------------------------------------------------------------------
module cse_store #(
	parameter int SEM_COUNT  = 16,
	parameter int PROC_COUNT = 32,
	parameter int ENT_W      = 19
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  cse_pkg::mem_ctrl_t                        ctrl,
	input  logic [$clog2(SEM_COUNT)-1:0]              ent_raddr,
	input  logic [$clog2(SEM_COUNT)-1:0]              ent_waddr,
	input  logic [ENT_W-1:0]                          ent_wdata,
	output logic [ENT_W-1:0]                          ent_rdata,
	input  logic [$clog2(SEM_COUNT)+$clog2(PROC_COUNT)-1:0] wt_raddr,
	input  logic [$clog2(SEM_COUNT)+$clog2(PROC_COUNT)-1:0] wt_waddr,
	input  logic [cse_pkg::PID_W-1:0]                 wt_wdata,
	output logic [cse_pkg::PID_W-1:0]                 wt_rdata
);
	import cse_pkg::*;

	localparam int PW       = $clog2(PROC_COUNT);
	localparam int WT_DEPTH = SEM_COUNT * (2 ** PW);

	logic [ENT_W-1:0] ent_mem [SEM_COUNT];
	logic [PID_W-1:0] wt_mem [WT_DEPTH];
	logic [SEM_COUNT-1:0] ent_vld_q;
	logic [ENT_W-1:0] ent_rd_q;
	logic ent_rd_vld_q;

	// entry memory, synchronous read
	always_ff @(posedge clk) begin
		if (ctrl.ent_wr) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (ctrl.ent_rd) begin
			ent_rd_q <= ent_mem[ent_raddr];
		end
	end

	// an entry never written reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q    <= '0;
			ent_rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.ent_wr) begin
				ent_vld_q[ent_waddr] <= 1'b1;
			end
			if (ctrl.ent_rd) begin
				ent_rd_vld_q <= ent_vld_q[ent_raddr];
			end
		end
	end

	assign ent_rdata = ent_rd_vld_q ? ent_rd_q : '0;

	// waiter memory, one fifo ring per semaphore
	always_ff @(posedge clk) begin
		if (ctrl.wt_wr) begin
			wt_mem[wt_waddr] <= wt_wdata;
		end
		if (ctrl.wt_rd) begin
			wt_rdata <= wt_mem[wt_raddr];
		end
	end

endmodule

// ===== rtl/counting_semaphore_engine.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_engine
// semaphore table with init / wait / post requests and fifo wait queues
// ----------------------------------------------------------------------------
//
// channel   dir   tdata (low bit up)                           tuser
// s_*       in    sem_id 4, caller_pid 5, initial_passes 8     func 2
// m_*       out   sem_id_out 4, woken_pid 5, woken_valid 1,    status 3
//                 passes_now 8
//
// a request has its table entry read at the accept edge, then modified and
// written back in the next cycle; a post that wakes a waiter then passes
// S_WAKE, since the waiter memory is addressed by the queue head just read.
// one request is in flight at a time; a new one is taken while the previous
// result still waits in the output register, and the engine holds a finished
// result until the output register frees up.
// no clearing pass after reset: table entries carry valid bits.
// ----------------------------------------------------------------------------
module counting_semaphore_engine #(
	parameter int SEM_COUNT  = 16,
	parameter int PROC_COUNT = 32,
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sem_id, caller_pid, initial_passes, zero fill
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // sem_id_out, woken_pid, woken_valid, passes_now, zero fill
	output logic [2:0]  m_tuser    // status
);
	import cse_pkg::*;

	localparam int SW    = $clog2(SEM_COUNT);
	localparam int PW    = $clog2(PROC_COUNT);
	localparam int LW    = $clog2(PROC_COUNT + 1);
	localparam int CW    = COUNT_BITS;
	localparam int EW    = CW + PW + LW;
	localparam int AW    = $clog2(SEM_COUNT + 1);
	localparam int MW    = (CW > PASS_IN_W) ? CW : PASS_IN_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WAKE,
		S_HOLD
	} state_t;

	state_t state_q;

	// request held for the modify cycle
	func_t               func_s1;
	logic [SW-1:0]       sid_s1;
	logic [PID_W-1:0]    pid_s1;
	logic [PASS_IN_W-1:0] init_s1;

	logic [AW-1:0]       alloc_q;   // ids handed out so far, in order
	result_t             res_q;     // result waiting for the output register
	logic                out_vld_q;
	result_t             out_q;

	// sem_id wrap table, one entry per 4-bit code
	logic [SW-1:0] sid_wrap [SID_VALS];
	for (genvar g = 0; g < SID_VALS; g++) begin : g_wrap
		assign sid_wrap[g] = SW'(g % SEM_COUNT);
	end

	logic s_acc;
	logic out_free;
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// storage interface
	mem_ctrl_t            ctrl;
	logic [SW-1:0]        ent_waddr;
	logic [EW-1:0]        ent_wdata;
	logic [EW-1:0]        ent_rdata;
	logic [SW+PW-1:0]     wt_raddr;
	logic [SW+PW-1:0]     wt_waddr;
	logic [PID_W-1:0]     wt_rdata;

	// entry fields after the read
	logic [CW-1:0] cnt;
	logic [PW-1:0] head;
	logic [LW-1:0] len;
	assign len  = ent_rdata[LW-1:0];
	assign head = ent_rdata[LW +: PW];
	assign cnt  = ent_rdata[LW+PW +: CW];

	logic [CW-1:0] new_cnt;
	logic [PW-1:0] new_head;
	logic [LW-1:0] new_len;
	logic          ent_wr;
	logic          wt_wr;
	logic          wt_rd;
	logic          alloc_take;
	logic          go_wake;
	result_t       res;

	logic [SW-1:0] alloc_id;
	logic          id_free;
	logic [CW-1:0] init_clamp;
	logic [MW-1:0] init_ext;
	logic [LW:0]   tail_sum;
	logic [PW-1:0] tail_slot;
	logic [PW-1:0] head_next;

	assign alloc_id  = alloc_q[SW-1:0];
	assign id_free   = (alloc_q != AW'(SEM_COUNT));
	assign init_ext  = MW'(init_s1);
	assign init_clamp = (init_ext > MW'(CNT_MAX)) ? CNT_MAX : CW'(init_ext);

	// tail slot of the ring: head + length, below twice the ring size
	assign tail_sum  = (LW+1)'(head) + (LW+1)'(len);
	assign tail_slot = (tail_sum >= (LW+1)'(PROC_COUNT))
		? PW'(tail_sum - (LW+1)'(PROC_COUNT)) : PW'(tail_sum);
	assign head_next = (head == PW'(PROC_COUNT - 1)) ? '0 : head + PW'(1);

	// modify step of the read-modify-write
	always_comb begin
		new_cnt          = cnt;
		new_head         = head;
		new_len          = len;
		ent_wr           = 1'b0;
		wt_wr            = 1'b0;
		wt_rd            = 1'b0;
		alloc_take       = 1'b0;
		go_wake          = 1'b0;
		res.status       = ST_GRANTED;
		res.sem_id_out   = SEM_ID_W'(sid_s1);
		res.woken_pid    = '0;
		res.woken_valid  = 1'b0;
		res.passes_now   = PASS_OUT_W'(cnt);
		case (func_s1)
			FN_INIT: begin
				if (id_free) begin
					ent_wr         = 1'b1;
					alloc_take     = 1'b1;
					new_cnt        = init_clamp;
					new_head       = '0;
					new_len        = '0;
					res.sem_id_out = SEM_ID_W'(alloc_id);
					res.passes_now = PASS_OUT_W'(init_clamp);
				end else begin
					res.status     = ST_NO_ID;
					res.sem_id_out = '0;
					res.passes_now = '0;
				end
			end
			FN_WAIT: begin
				if (cnt != '0) begin
					ent_wr         = 1'b1;
					new_cnt        = cnt - CW'(1);
					res.passes_now = PASS_OUT_W'(new_cnt);
				end else if (len == LW'(PROC_COUNT)) begin
					res.status     = ST_FULL;
					res.passes_now = '0;
				end else begin
					ent_wr         = 1'b1;
					wt_wr          = 1'b1;
					new_len        = len + LW'(1);
					res.status     = ST_BLOCKED;
					res.passes_now = '0;
				end
			end
			FN_POST: begin
				if (len != '0) begin
					// pid comes from the waiter memory read, in state S_WAKE
					ent_wr          = 1'b1;
					wt_rd           = 1'b1;
					go_wake         = 1'b1;
					new_head        = head_next;
					new_len         = len - LW'(1);
					res.status      = ST_WOKEN;
					res.woken_valid = 1'b1;
				end else if (cnt == CNT_MAX) begin
					res.status = ST_SATURATED;
				end else begin
					ent_wr         = 1'b1;
					new_cnt        = cnt + CW'(1);
					res.passes_now = PASS_OUT_W'(new_cnt);
				end
			end
			default: begin
			end
		endcase
	end

	logic in_read;
	assign in_read     = (state_q == S_READ);
	assign ctrl.ent_rd = s_acc;
	assign ctrl.ent_wr = in_read && ent_wr;
	assign ctrl.wt_rd  = in_read && wt_rd;
	assign ctrl.wt_wr  = in_read && wt_wr;
	assign ent_waddr   = (func_s1 == FN_INIT) ? alloc_id : sid_s1;
	assign ent_wdata   = {new_cnt, new_head, new_len};
	assign wt_raddr    = {sid_s1, head};
	assign wt_waddr    = {sid_s1, tail_slot};

	cse_store #(
		.SEM_COUNT  (SEM_COUNT),
		.PROC_COUNT (PROC_COUNT),
		.ENT_W      (EW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.ent_raddr (sid_wrap[s_tdata[3:0]]),
		.ent_waddr (ent_waddr),
		.ent_wdata (ent_wdata),
		.ent_rdata (ent_rdata),
		.wt_raddr  (wt_raddr),
		.wt_waddr  (wt_waddr),
		.wt_wdata  (pid_s1),
		.wt_rdata  (wt_rdata)
	);

	// woken result, pid filled in from the waiter read
	result_t wake_res;
	always_comb begin
		wake_res           = res_q;
		wake_res.woken_pid = wt_rdata;
	end

	// a finished result moves into the output register this cycle
	logic out_load;
	assign out_load = out_free && ((state_q == S_READ && !go_wake) ||
		state_q == S_WAKE || state_q == S_HOLD);

	// request capture, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s1 <= func_t'(s_tuser);
			sid_s1  <= sid_wrap[s_tdata[3:0]];
			pid_s1  <= s_tdata[8:4];
			init_s1 <= s_tdata[16:9];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			alloc_q   <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			res_q     <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (alloc_take) begin
						alloc_q <= alloc_q + AW'(1);
					end
					if (go_wake) begin
						res_q   <= res;
						state_q <= S_WAKE;
					end else if (out_free) begin
						out_q   <= res;
						state_q <= S_IDLE;
					end else begin
						res_q   <= res;
						state_q <= S_HOLD;
					end
				end
				S_WAKE: begin
					if (out_free) begin
						out_q   <= wake_res;
						state_q <= S_IDLE;
					end else begin
						res_q   <= wake_res;
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {6'b0, out_q.passes_now, out_q.woken_valid, out_q.woken_pid,
		out_q.sem_id_out};

endmodule

// ===== rtl/cse_checker.sv =====
// ----------------------------------------------------------------------------
// cse_checker
// port-level checks of the semaphore engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import cse_pkg::*;

	// stalled result holds
	`ASSERT_CLKD(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one request in flight: no accept right after an accept
	`ASSERT_CLKD(a_one_inflight, s_tvalid && s_tready |=> !s_tready)

	// woken flag set exactly on a woken result
	`ASSERT_CLKD(a_woken_flag, m_tvalid |-> (m_tdata[9] == (m_tuser == ST_WOKEN)))

	// no woken pid without the flag
	`ASSERT_CLKD(a_woken_pid_zero, m_tvalid && !m_tdata[9] |-> m_tdata[8:4] == 5'd0)

	// exhausted free list gives an all-zero payload
	`ASSERT_CLKD(a_no_id_zero, m_tvalid && (m_tuser == ST_NO_ID) |-> m_tdata == 24'd0)

endmodule

bind counting_semaphore_engine cse_checker u_cse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the semaphore engine: init / wait / post requests go
// in on the slave stream, a table predictor keeps its own copy of the counts,
// wait queues and free list and checks each result in order of acceptance
// ----------------------------------------------------------------------------
module tb_top;
	import cse_pkg::*;

	localparam int SEMS         = 16;
	localparam int WAIT_DEPTH   = 32;
	localparam int MAX_PASSES   = 255;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	// table predictor with the queue of results still to arrive
	class sem_table_checker;
		logic [7:0] pass_count   [SEMS];
		logic [4:0] waiter_pid   [SEMS][WAIT_DEPTH];
		logic [4:0] queue_head   [SEMS];
		logic [5:0] queue_length [SEMS];
		logic [3:0] free_ids     [SEMS];
		logic [3:0] free_head;
		logic [4:0] free_length;
		result_t    pending_results [$];
		int         mismatches;

		function new();
			for (int i = 0; i < SEMS; i++) begin
				pass_count[i]   = '0;
				queue_head[i]   = '0;
				queue_length[i] = '0;
				free_ids[i]     = 4'(i);
			end
			free_head   = '0;
			free_length = 5'(SEMS);
			mismatches  = 0;
		endfunction

		// work out the result of an accepted request and update the table
		function void note_request(func_t fn, logic [3:0] sid, logic [4:0] pid,
				logic [7:0] passes);
			result_t    r;
			logic [3:0] id;
			logic [4:0] slot;
			r = '0;
			r.status = ST_GRANTED;
			r.sem_id_out = sid;
			case (fn)
				FN_INIT: begin
					if (free_length == 0) begin
						r.status = ST_NO_ID;
						r.sem_id_out = '0;
					end else begin
						id = free_ids[free_head];
						free_head = free_head + 1'b1;
						free_length = free_length - 1'b1;
						// an 8 bit start count never exceeds the ceiling
						pass_count[id] = passes;
						queue_head[id] = '0;
						queue_length[id] = '0;
						r.sem_id_out = id;
						r.passes_now = passes;
					end
				end
				FN_WAIT: begin
					if (pass_count[sid] != 0) begin
						pass_count[sid] = pass_count[sid] - 1'b1;
						r.passes_now = pass_count[sid];
					end else if (queue_length[sid] >= WAIT_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slot = queue_head[sid] + queue_length[sid][4:0];
						waiter_pid[sid][slot] = pid;
						queue_length[sid] = queue_length[sid] + 1'b1;
						r.status = ST_BLOCKED;
					end
				end
				FN_POST: begin
					if (queue_length[sid] != 0) begin
						r.status = ST_WOKEN;
						r.woken_pid = waiter_pid[sid][queue_head[sid]];
						r.woken_valid = 1'b1;
						r.passes_now = pass_count[sid];
						queue_head[sid] = queue_head[sid] + 1'b1;
						queue_length[sid] = queue_length[sid] - 1'b1;
					end else if (pass_count[sid] == MAX_PASSES) begin
						r.status = ST_SATURATED;
						r.passes_now = pass_count[sid];
					end else begin
						pass_count[sid] = pass_count[sid] + 1'b1;
						r.passes_now = pass_count[sid];
					end
				end
				default: begin
					r.passes_now = pass_count[sid];
				end
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("result with no request pending: status %0d id %0d",
						got.status, got.sem_id_out);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.sem_id_out !== want.sem_id_out ||
					got.woken_pid !== want.woken_pid ||
					got.woken_valid !== want.woken_valid ||
					got.passes_now !== want.passes_now) begin
				// each pair is expected/actual
				if (mismatches < 10)
					$display("mismatch st %0d/%0d id %0d/%0d pid %0d/%0d wv %0d/%0d pass %0d/%0d",
						want.status, got.status, want.sem_id_out, got.sem_id_out,
						want.woken_pid, got.woken_pid, want.woken_valid,
						got.woken_valid, want.passes_now, got.passes_now);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	sem_table_checker chk = new();

	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int hold_off_requests = 0;
	int items_sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	counting_semaphore_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// offer one request, with random gaps ahead of it, and log it once taken
	task automatic issue_request(func_t fn, logic [3:0] sid, logic [4:0] pid,
			logic [7:0] passes);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		// sem_id, caller_pid, initial_passes, zero fill
		s_tdata  <= {7'd0, passes, pid, sid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chk.note_request(fn, sid, pid, passes);
		items_sent++;
	endtask

	function automatic logic [7:0] pick_passes();
		int r;
		r = $urandom_range(3);
		if (r == 0)
			return 8'd0;
		else if (r == 1)
			return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	// mix of lone requests and wait / post runs on one semaphore
	task automatic random_requests(int stop_at);
		int         kind;
		int         n;
		int         r;
		logic [3:0] sid;
		while (items_sent < stop_at) begin
			kind = $urandom_range(99);
			sid = 4'($urandom_range(15));
			if (kind < 50) begin
				r = $urandom_range(99);
				if (r < 5)
					issue_request(FN_INIT, sid, 5'($urandom_range(31)), pick_passes());
				else if (r < 48)
					issue_request(FN_WAIT, sid, 5'($urandom_range(31)), pick_passes());
				else if (r < 93)
					issue_request(FN_POST, sid, 5'($urandom_range(31)), pick_passes());
				else
					issue_request(FN_NOP, sid, 5'($urandom_range(31)), pick_passes());
			end else if (kind < 85) begin
				// short run of waits, blocking once the count is zero, and as many posts
				n = $urandom_range(1, 8);
				repeat (n)
					issue_request(FN_WAIT, sid, 5'($urandom_range(31)), pick_passes());
				repeat (n)
					issue_request(FN_POST, sid, 5'($urandom_range(31)), pick_passes());
			end else if (kind < 95) begin
				// drain the count and then fill, and possibly overrun, the wait queue
				if (chk.pass_count[sid] <= 16) begin
					n = chk.pass_count[sid] + $urandom_range(30, 34);
					repeat (n)
						issue_request(FN_WAIT, sid, 5'($urandom_range(31)), pick_passes());
					repeat (n + $urandom_range(0, 3))
						issue_request(FN_POST, sid, 5'($urandom_range(31)), pick_passes());
				end
			end else begin
				// push a nearly full count, where there is one, into saturation
				for (int i = 0; i < SEMS; i++)
					if (chk.pass_count[i] >= 248)
						sid = 4'(i);
				repeat (10)
					issue_request(FN_POST, sid, 5'($urandom_range(31)), pick_passes());
			end
		end
	endtask

	initial begin : result_sink
		result_t got;
		int      hold_left;
		int      hold_seen;
		hold_left = 0;
		hold_seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				// sem_id_out, woken_pid, woken_valid, passes_now from the low bits
				got.status      = status_t'(m_tuser);
				got.sem_id_out  = m_tdata[3:0];
				got.woken_pid   = m_tdata[8:4];
				got.woken_valid = m_tdata[9];
				got.passes_now  = m_tdata[17:10];
				chk.check_result(got);
			end
			// long hold-off lets the engine back up into its input
			if (hold_seen != hold_off_requests) begin
				hold_seen = hold_off_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first phase: sender rarely idles, receiver often stalls
		src_idle_pct = 12;
		dst_idle_pct = 66;

		// never initialized semaphore: unused code, block, wake, count up and down
		issue_request(FN_NOP,  4'd0,  5'd0,  8'd0);
		issue_request(FN_WAIT, 4'd5,  5'd31, 8'd0);
		issue_request(FN_POST, 4'd5,  5'd0,  8'd0);
		issue_request(FN_POST, 4'd5,  5'd0,  8'd0);
		issue_request(FN_WAIT, 4'd5,  5'd7,  8'd0);
		// init at both count extremes
		issue_request(FN_INIT, 4'd0,  5'd0,  8'd0);
		issue_request(FN_INIT, 4'd15, 5'd31, 8'd255);
		// post on a full count saturates
		issue_request(FN_POST, 4'd1,  5'd3,  8'd0);
		issue_request(FN_WAIT, 4'd1,  5'd4,  8'd0);
		issue_request(FN_POST, 4'd1,  5'd5,  8'd0);
		// two waiters released in arrival order
		issue_request(FN_WAIT, 4'd0,  5'd0,  8'd0);
		issue_request(FN_WAIT, 4'd0,  5'd21, 8'd0);
		issue_request(FN_POST, 4'd0,  5'd9,  8'd0);
		issue_request(FN_POST, 4'd0,  5'd9,  8'd0);
		issue_request(FN_POST, 4'd0,  5'd9,  8'd0);
		// all-ones fields
		issue_request(FN_NOP,  4'd15, 5'd31, 8'd255);
		issue_request(FN_WAIT, 4'd15, 5'd10, 8'd255);
		issue_request(FN_POST, 4'd15, 5'd31, 8'd255);
		issue_request(FN_INIT, 4'd15, 5'd31, 8'd128);

		random_requests(380);

		// second phase: sender often idles, receiver rarely stalls
		src_idle_pct = 66;
		dst_idle_pct = 12;
		random_requests(740);

		// last phase: no idling, opening with a long receiver hold-off
		src_idle_pct = 0;
		dst_idle_pct = 0;
		hold_off_requests++;
		random_requests(1100);

		s_tvalid <= 1'b0;
		while (chk.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
